FILE: hw/rtl/qss_pkg.sv
// Shared types, constants and helpers for the quoted string scanner.
// No dependencies; every other file of the block imports this package.
package qss_pkg;

  localparam int unsigned CHAR_W = 7;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CFG_W  = 64;

  // Hard upper bound on the usable capacity
  localparam logic [LEN_W-1:0] LEN_BOUND = 13'd4096;

  // Register reset values: only double and single quote may open a field,
  // tab and the printables are allowed inside
  localparam logic [CFG_W-1:0] FIRST_LOW_RST    = 64'hFFFF_FFFF_DEFF_FFFF;
  localparam logic [CFG_W-1:0] FIRST_HIGH_RST   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [CFG_W-1:0] CONTENT_LOW_RST  = 64'hFFBF_FFFF_0000_0000;
  localparam logic [CFG_W-1:0] CONTENT_HIGH_RST = 64'h0000_0000_0000_0001;
  localparam logic [LEN_W-1:0] OUT_CAP_RST      = 13'd256;

  typedef enum logic [IDX_W-1:0] {
    REG_FIRST_LOW    = 3'd0,
    REG_FIRST_HIGH   = 3'd1,
    REG_CONTENT_LOW  = 3'd2,
    REG_CONTENT_HIGH = 3'd3,
    REG_OUT_CAP      = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IN_STRING     = 3'd0,
    ST_QUOTE_PENDING = 3'd1,
    ST_TERMINATED    = 3'd2,
    ST_BAD_QUOTE     = 3'd3,
    ST_BAD_CHAR      = 3'd4,
    ST_OVERFLOW      = 3'd5,
    ST_IDLE          = 3'd6
  } status_t;

  // Classified request handed from the front end to the back end
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              start;
    logic              barred;  // unflagged and marked in the applicable bitmap
  } item_t;

  // Bitmap lookup: bit 63-i of the low word is char i, of the high word char 64+i
  function automatic logic map_bit(input logic [CFG_W-1:0] lo,
                                   input logic [CFG_W-1:0] hi,
                                   input logic [CHAR_W-1:0] ch);
    logic [5:0] pos;
    pos = ~ch[5:0];
    return ch[6] ? hi[pos] : lo[pos];
  endfunction

endpackage

FILE: hw/rtl/qss_front.sv
// Front end: configuration registers, input handshake and bitmap classification.
// Depends on qss_pkg.
module qss_front import qss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] character,
  input  logic              prequoted,
  input  logic              start_field,
  input  logic              q_full,
  output logic              push,
  output item_t             push_item,
  output logic [LEN_W-1:0]  cap
);

  logic [CFG_W-1:0] first_low;
  logic [CFG_W-1:0] first_high;
  logic [CFG_W-1:0] content_low;
  logic [CFG_W-1:0] content_high;
  logic [LEN_W-1:0] out_cap;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      first_low    <= FIRST_LOW_RST;
      first_high   <= FIRST_HIGH_RST;
      content_low  <= CONTENT_LOW_RST;
      content_high <= CONTENT_HIGH_RST;
      out_cap      <= OUT_CAP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FIRST_LOW:    first_low    <= cfg_data;
        REG_FIRST_HIGH:   first_high   <= cfg_data;
        REG_CONTENT_LOW:  content_low  <= cfg_data;
        REG_CONTENT_HIGH: content_high <= cfg_data;
        REG_OUT_CAP:      out_cap      <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective capacity is clamped to the bound
  assign cap = (out_cap > LEN_BOUND) ? LEN_BOUND : out_cap;

  // Take a request whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Classify: the quote uses the first-position map, later chars the content map
  always_comb begin
    push_item.ch     = character;
    push_item.start  = start_field;
    push_item.barred = !prequoted && (start_field ?
                       map_bit(first_low, first_high, character) :
                       map_bit(content_low, content_high, character));
  end

endmodule

FILE: hw/rtl/qss_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Depends on qss_pkg.
module qss_queue import qss_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output item_t head
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  // Pointer and fill bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  assign full       = fill[1];
  assign head_valid = (fill != 2'd0);
  assign head       = slots[rd_ptr];

endmodule

FILE: hw/rtl/qss_back.sv
// Back end: scanner state, result computation and the output register.
// Depends on qss_pkg.
module qss_back import qss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  item_t             head,
  input  logic [LEN_W-1:0]  cap,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_valid,
  output logic [2:0]        status,
  output logic [LEN_W-1:0]  string_length
);

  logic [CHAR_W-1:0] quote_char;
  logic              pending_quote;
  logic [LEN_W-1:0]  count;
  logic              active;

  logic [CHAR_W-1:0] quote_char_next;
  logic              pending_quote_next;
  logic [LEN_W-1:0]  count_next;
  logic              active_next;
  logic [CHAR_W-1:0] oc_next;
  logic              ov_next;
  status_t           st_next;

  logic              over_one;
  logic              over_two;

  // Issue when the output register is empty or being drained
  assign pop = head_valid && (!res_valid || !res_stall);

  // Capacity checks: length plus terminator must fit
  assign over_one = ({1'b0, count} + 14'd1) > {1'b0, cap};
  assign over_two = ({1'b0, count} + 14'd2) > {1'b0, cap};

  // Per-character decision
  always_comb begin
    quote_char_next    = quote_char;
    pending_quote_next = pending_quote;
    count_next         = count;
    active_next        = active;
    oc_next            = '0;
    ov_next            = 1'b0;
    st_next            = ST_IDLE;
    if (head.start) begin
      count_next         = '0;
      pending_quote_next = 1'b0;
      if (head.barred) begin
        active_next = 1'b0;
        st_next     = ST_BAD_QUOTE;
      end else begin
        quote_char_next = head.ch;
        active_next     = 1'b1;
        st_next         = ST_IN_STRING;
      end
    end else if (!active) begin
      st_next = ST_IDLE;
    end else if (head.ch == quote_char) begin
      if (pending_quote) begin
        pending_quote_next = 1'b0;
        if (over_two) begin
          active_next = 1'b0;
          st_next     = ST_OVERFLOW;
        end else begin
          // doubled quote stands for one quote
          count_next = count + 1'b1;
          oc_next    = head.ch;
          ov_next    = 1'b1;
          st_next    = ST_IN_STRING;
        end
      end else begin
        pending_quote_next = 1'b1;
        st_next            = ST_QUOTE_PENDING;
      end
    end else if (pending_quote) begin
      // lone quote: field ends here
      pending_quote_next = 1'b0;
      active_next        = 1'b0;
      st_next            = over_one ? ST_OVERFLOW : ST_TERMINATED;
    end else if (head.barred) begin
      active_next = 1'b0;
      st_next     = ST_BAD_CHAR;
    end else if (over_two) begin
      active_next = 1'b0;
      st_next     = ST_OVERFLOW;
    end else begin
      count_next = count + 1'b1;
      oc_next    = head.ch;
      ov_next    = 1'b1;
      st_next    = ST_IN_STRING;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_char    <= '0;
      pending_quote <= 1'b0;
      count         <= '0;
      active        <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (pop) begin
        quote_char    <= quote_char_next;
        pending_quote <= pending_quote_next;
        count         <= count_next;
        active        <= active_next;
        res_valid     <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_char      <= oc_next;
      out_valid     <= ov_next;
      status        <= st_next;
      string_length <= count_next;
    end
  end

endmodule

FILE: hw/rtl/quoted_string_scanner_core.sv
// Quoted string scanner: one result per character; a request passes the queue, then
// the output register. Throughput is one character per cycle unless a side stalls;
// the two-entry queue and the output register let either side stall without loss.
// Reset (synchronous, active high) restores the register defaults, empties the
// queue and leaves the scanner idle with a zero length.
// Depends on qss_pkg, qss_front, qss_queue and qss_back.
module quoted_string_scanner_core import qss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] character,
  input  logic              prequoted,
  input  logic              start_field,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_valid,
  output logic [2:0]        status,
  output logic [LEN_W-1:0]  string_length
);

  logic             push;
  item_t            push_item;
  logic             q_full;
  logic             head_valid;
  item_t            head;
  logic             pop;
  logic [LEN_W-1:0] cap;

  qss_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .character   (character),
    .prequoted   (prequoted),
    .start_field (start_field),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item),
    .cap         (cap)
  );

  qss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  qss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .cap           (cap),
    .pop           (pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .out_char      (out_char),
    .out_valid     (out_valid),
    .status        (status),
    .string_length (string_length)
  );

endmodule

FILE: hw/rtl/qss_checker.sv
// Port-level checks for the quoted string scanner, bound to the top level.
// Depends on qss_pkg and quoted_string_scanner_core.
module qss_checker import qss_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_stall,
  input logic [CHAR_W-1:0] out_char,
  input logic              out_valid,
  input logic [2:0]        status,
  input logic [LEN_W-1:0]  string_length
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_char) && $stable(status)
      && $stable(string_length) && $stable(out_valid))
    else $error("stalled result changed");

  // An emitted character is part of a string that has at least one character
  a_emit: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid |-> status == ST_IN_STRING && string_length != '0)
    else $error("emitted character without in-string status");

  // A refused quote starts an empty field
  a_bad_quote: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_BAD_QUOTE |-> string_length == '0 && !out_valid)
    else $error("bad quote with nonzero length or output");

endmodule

bind quoted_string_scanner_core qss_checker u_qss_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res_valid),
  .res_stall     (res_stall),
  .out_char      (out_char),
  .out_valid     (out_valid),
  .status        (status),
  .string_length (string_length)
);

FILE: bench/testbench.sv
// Self-checking bench for quoted_string_scanner_core: directed table, then random fields
// under several register settings and flow-control mixes. Depends on qss_pkg and the core.
`timescale 1ns / 100ps

module testbench;
  import qss_pkg::*;

  // Character codes used by the directed table
  localparam logic [CHAR_W-1:0] CH_NUL = 7'h00;
  localparam logic [CHAR_W-1:0] CH_TAB = 7'h09;
  localparam logic [CHAR_W-1:0] CH_DQ  = 7'h22;
  localparam logic [CHAR_W-1:0] CH_SQ  = 7'h27;
  localparam logic [CHAR_W-1:0] CH_UA  = 7'h41;
  localparam logic [CHAR_W-1:0] CH_LA  = 7'h61;
  localparam logic [CHAR_W-1:0] CH_LB  = 7'h62;
  localparam logic [CHAR_W-1:0] CH_LH  = 7'h68;
  localparam logic [CHAR_W-1:0] CH_LX  = 7'h78;
  localparam logic [CHAR_W-1:0] CH_LY  = 7'h79;
  localparam logic [CHAR_W-1:0] CH_TIL = 7'h7E;
  localparam logic [CHAR_W-1:0] CH_DEL = 7'h7F;

  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PER_PHASE   = 20;
  localparam int PLAN_LEN    = 30;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              valid;
    status_t           status;
    logic [LEN_W-1:0]  len;
  } scan_t;

  typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [LEN_W-1:0]  cap;
    logic [CHAR_W-1:0] ch;
    logic              pq;
    logic              start;
    logic              typed;
    scan_t             want;
  } step_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [CHAR_W-1:0] character;
  logic              prequoted;
  logic              start_field;
  logic              res_valid;
  logic              res_stall = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic              out_valid;
  logic [2:0]        status;
  logic [LEN_W-1:0]  string_length;

  quoted_string_scanner_core uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .character(character), .prequoted(prequoted), .start_field(start_field),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_char(out_char), .out_valid(out_valid), .status(status),
    .string_length(string_length)
  );

  // Directed table; typed rows carry their expected result, others use the predictor
  step_t plan [PLAN_LEN] = '{
    '{ROW_REQ, 13'd0, CH_LA,  1'b0, 1'b0, 1'b1, '{CH_NUL, 1'b0, ST_IDLE, 13'd0}},
    '{ROW_REQ, 13'd0, CH_UA,  1'b0, 1'b1, 1'b1, '{CH_NUL, 1'b0, ST_BAD_QUOTE, 13'd0}},
    '{ROW_REQ, 13'd0, CH_DQ,  1'b0, 1'b1, 1'b1, '{CH_NUL, 1'b0, ST_IN_STRING, 13'd0}},
    '{ROW_REQ, 13'd0, CH_LH,  1'b0, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_DQ,  1'b0, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_DQ,  1'b0, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_DEL, 1'b1, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_DQ,  1'b1, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_LX,  1'b0, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_LY,  1'b0, 1'b0, 1'b1, '{CH_NUL, 1'b0, ST_IDLE, 13'd3}},
    '{ROW_REQ, 13'd0, CH_UA,  1'b1, 1'b1, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_TAB, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_DQ,  1'b0, 1'b1, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_DEL, 1'b0, 1'b0, 1'b1, '{CH_NUL, 1'b0, ST_BAD_CHAR, 13'd0}},
    '{ROW_REQ, 13'd0, CH_NUL, 1'b1, 1'b1, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_NUL, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_DEL, 1'b1, 1'b0, 1'b0, '0},
    '{ROW_CAP, 13'd1, CH_NUL, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_SQ,  1'b0, 1'b1, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_LA,  1'b0, 1'b0, 1'b1, '{CH_NUL, 1'b0, ST_OVERFLOW, 13'd0}},
    '{ROW_CAP, 13'd0, CH_NUL, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_DQ,  1'b0, 1'b1, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_DQ,  1'b0, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_LB,  1'b0, 1'b0, 1'b1, '{CH_NUL, 1'b0, ST_OVERFLOW, 13'd0}},
    '{ROW_CAP, 13'd2, CH_NUL, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_DQ,  1'b0, 1'b1, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_LA,  1'b0, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_DQ,  1'b0, 1'b0, 1'b0, '0},
    '{ROW_REQ, 13'd0, CH_DQ,  1'b0, 1'b0, 1'b1, '{CH_NUL, 1'b0, ST_OVERFLOW, 13'd1}},
    '{ROW_REQ, 13'd0, CH_TIL, 1'b0, 1'b0, 1'b1, '{CH_NUL, 1'b0, ST_IDLE, 13'd1}}
  };

  // Scanner shadow: register copies and field state
  logic [CFG_W-1:0]  fb_lo, fb_hi, cb_lo, cb_hi;
  logic [LEN_W-1:0]  cap_reg;
  logic [CHAR_W-1:0] q_char;
  logic              pend;
  logic              live;
  int                len_cnt;

  scan_t awaited_results [$];
  int    errors = 0;
  int    checked = 0;
  int    accepted = 0;
  int    live_count = 0;
  int    settings_loaded = 0;
  int    status_seen [7];
  int    send_pct = 0;
  int    stall_pct = 0;
  int    hold_req_cnt = 0;
  int    hold_seen = 0;
  int    hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Bitmap lookup: bit 63-k of the selected word stands for code k of that half
  function automatic logic barred(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                  input logic [CHAR_W-1:0] c);
    int bitpos;
    bitpos = 63 - int'(c[5:0]);
    return c[6] ? hi[bitpos] : lo[bitpos];
  endfunction

  // Advance the shadow scanner by one character and return its result
  function automatic scan_t scan_char(input logic [CHAR_W-1:0] c, input logic pq,
                                      input logic st);
    scan_t r;
    int    lim;
    r = '0;
    r.status = ST_IDLE;
    lim = int'(cap_reg);
    if (lim > int'(LEN_BOUND)) lim = int'(LEN_BOUND);
    if (st) begin
      len_cnt = 0;
      pend = 1'b0;
      if (!pq && barred(fb_lo, fb_hi, c)) begin
        live = 1'b0;
        r.status = ST_BAD_QUOTE;
      end else begin
        q_char = c;
        live = 1'b1;
        r.status = ST_IN_STRING;
      end
    end else if (!live) begin
      r.status = ST_IDLE;
    end else if (c == q_char) begin
      // quote matched on the code alone, flagged or not
      if (pend) begin
        pend = 1'b0;
        if (len_cnt + 2 > lim) begin
          live = 1'b0;
          r.status = ST_OVERFLOW;
        end else begin
          len_cnt++;
          r.ch = c;
          r.valid = 1'b1;
          r.status = ST_IN_STRING;
        end
      end else begin
        pend = 1'b1;
        r.status = ST_QUOTE_PENDING;
      end
    end else if (pend) begin
      // lone quote closes the field; terminator itself is dropped
      pend = 1'b0;
      live = 1'b0;
      r.status = (len_cnt + 1 > lim) ? ST_OVERFLOW : ST_TERMINATED;
    end else if (!pq && barred(cb_lo, cb_hi, c)) begin
      live = 1'b0;
      r.status = ST_BAD_CHAR;
    end else if (len_cnt + 2 > lim) begin
      live = 1'b0;
      r.status = ST_OVERFLOW;
    end else begin
      len_cnt++;
      r.ch = c;
      r.valid = 1'b1;
      r.status = ST_IN_STRING;
    end
    r.len = len_cnt[LEN_W-1:0];
    return r;
  endfunction

  // Offer one request, hold it until accepted, then record its expected result
  task automatic drive_request(input logic [CHAR_W-1:0] c, input logic pq, input logic st,
                               input logic typed, input scan_t want);
    scan_t pred;
    while (send_pct > 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    character <= c;
    prequoted <= pq;
    start_field <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = scan_char(c, pq, st);
    awaited_results.push_back(typed ? want : pred);
    accepted++;
    if (pred.status != ST_IDLE) live_count++;
  endtask

  // Stop offering and let every outstanding result come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all five registers one after another, in index order
  task automatic load_settings(input logic [CFG_W-1:0] f_lo, input logic [CFG_W-1:0] f_hi,
                               input logic [CFG_W-1:0] c_lo, input logic [CFG_W-1:0] c_hi,
                               input logic [CFG_W-1:0] cap_word);
    reg_idx_t         r;
    logic [CFG_W-1:0] vals [5];
    vals = '{f_lo, f_hi, c_lo, c_hi, cap_word};
    r = r.first();
    repeat (r.num()) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= r;
      cfg_data <= vals[r];
      @(posedge clk);
      r = r.next();
    end
    cfg_wr_en <= 1'b0;
    fb_lo = f_lo;
    fb_hi = f_hi;
    cb_lo = c_lo;
    cb_hi = c_hi;
    cap_reg = cap_word[LEN_W-1:0];
    settings_loaded++;
  endtask

  // One well-formed field: quote, content with doubled quotes, usually a proper close
  task automatic emit_field(input int n);
    logic [CHAR_W-1:0] q, c;
    logic              f;
    int                k, sel;
    sel = $urandom_range(3);
    q = (sel == 0) ? CH_DQ : (sel == 1) ? CH_SQ : CHAR_W'($urandom_range(127));
    f = barred(fb_lo, fb_hi, q) ? ($urandom_range(9) != 0) : ($urandom_range(5) == 0);
    drive_request(q, f, 1'b1, 1'b0, '0);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(7) == 0) begin
        drive_request(q, 1'($urandom_range(1)), 1'b0, 1'b0, '0);
        drive_request(q, 1'($urandom_range(1)), 1'b0, 1'b0, '0);
      end else begin
        c = CHAR_W'($urandom_range(127));
        if (c == q) c = c ^ 7'h01;
        f = barred(cb_lo, cb_hi, c) ? ($urandom_range(15) != 0) : ($urandom_range(7) == 0);
        drive_request(c, f, 1'b0, 1'b0, '0);
      end
    end
    sel = $urandom_range(9);
    if (sel != 0) drive_request(q, 1'($urandom_range(1)), 1'b0, 1'b0, '0);
    if (sel > 1) begin
      c = CHAR_W'($urandom_range(127));
      if (c == q) c = c ^ 7'h01;
      drive_request(c, 1'($urandom_range(1)), 1'b0, 1'b0, '0);
    end
  endtask

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen <= hold_req_cnt;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
    end
  end

  // Result checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    scan_t w;
    if (!rst && res_valid && !res_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: status %0d length %0d",
               status, string_length);
        errors++;
      end else begin
        w = awaited_results.pop_front();
        checked++;
        if (status < 3'd7) status_seen[status]++;
        if (out_char !== w.ch) begin
          $error("out_char expected %0h actual %0h", w.ch, out_char);
          errors++;
        end
        if (out_valid !== w.valid) begin
          $error("out_valid expected %0b actual %0b", w.valid, out_valid);
          errors++;
        end
        if (status !== w.status) begin
          $error("status expected %0d actual %0d", w.status, status);
          errors++;
        end
        if (string_length !== w.len) begin
          $error("string_length expected %0d actual %0d", w.len, string_length);
          errors++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    int ph, target, i, k;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_FIRST_LOW;
    cfg_data <= '0;
    in_valid <= 1'b0;
    character <= '0;
    prequoted <= 1'b0;
    start_field <= 1'b0;
    fb_lo = FIRST_LOW_RST;
    fb_hi = FIRST_HIGH_RST;
    cb_lo = CONTENT_LOW_RST;
    cb_hi = CONTENT_HIGH_RST;
    cap_reg = OUT_CAP_RST;
    q_char = '0;
    pend = 1'b0;
    live = 1'b0;
    len_cnt = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, starting from reset register values
    for (i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_CAP) begin
        wait_for_results();
        load_settings(FIRST_LOW_RST, FIRST_HIGH_RST, CONTENT_LOW_RST, CONTENT_HIGH_RST,
                      {51'd0, plan[i].cap});
      end else begin
        drive_request(plan[i].ch, plan[i].pq, plan[i].start, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each with its own settings and flow-control mix
    for (ph = 0; ph < PHASES; ph++) begin
      wait_for_results();
      case (ph)
        0: load_settings(FIRST_LOW_RST, FIRST_HIGH_RST, CONTENT_LOW_RST, CONTENT_HIGH_RST,
                         {51'd0, OUT_CAP_RST});
        1: load_settings('0, '0, '0, '0, 64'd4096);
        2: load_settings('1, '1, '1, '1, 64'h1FFF);
        3: load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, 64'($urandom_range(16, 2)));
        4: load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, 64'd0);
        5: load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, 64'd1);
        // upper bits of the capacity word are ignored by the block
        6: load_settings({$urandom, $urandom} & {$urandom, $urandom},
                         {$urandom, $urandom} & {$urandom, $urandom},
                         {$urandom, $urandom} & {$urandom, $urandom},
                         {$urandom, $urandom} & {$urandom, $urandom},
                         {$urandom, 19'($urandom), 13'd20});
        default: load_settings({$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom},
                               64'($urandom_range(64, 1)));
      endcase
      case (ph % 4)
        0: begin send_pct <= 0;  stall_pct <= 0;  end
        1: begin send_pct <= 85; stall_pct <= 0;  end
        2: begin send_pct <= 0;  stall_pct <= 85; end
        default: begin send_pct <= 31; stall_pct <= 31; end
      endcase
      // long hold-off on the result side while requests keep coming
      if (ph == 4) hold_req_cnt <= hold_req_cnt + 1;
      @(posedge clk);
      // one field long enough to reach the default capacity
      if (ph == 0) emit_field(260);
      target = live_count + PER_PHASE;
      while (live_count < target) begin
        if ($urandom_range(99) < 75) begin
          emit_field(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12));
        end else begin
          for (k = $urandom_range(4, 1); k > 0; k--)
            drive_request(CHAR_W'($urandom_range(127)), 1'($urandom_range(1)),
                          $urandom_range(3) == 0, 1'b0, '0);
        end
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    errors += awaited_results.size();
    $display("Run: %0d requests (%0d outside idle), %0d results checked, %0d register sets",
             accepted, live_count, checked, settings_loaded);
    $display("Statuses: in %0d pend %0d term %0d badq %0d badc %0d ovf %0d idle %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
